/* rtl/core/uttq_pkg.sv */
`default_nettype none

package uttq_pkg;

   localparam int FIFO_DEPTH = 8;
   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   // command queue between front and back, result queue at the output
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
   localparam int RSPQ_DEPTH = 2;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_RX_BYTE    = 2'd0,
      OP_TX_EMPTY   = 2'd1,
      OP_HOST_WRITE = 2'd2,
      OP_HOST_READ  = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] data;
   } req_item_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_char;
      logic       tx_irq_enable;
      logic       write_accepted;
      logic       read_valid;
      logic [7:0] read_char;
      logic       wake_writer;
      logic       rx_dropped;
   } rsp_item_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/uart_tty_queue_engine.sv */
`default_nettype none

// channel   ports                          item
// -------   ----------------------------   -----------------------------------
// request   push, full, req_item           req_type, data
// response  empty, pop, rsp_item           tx/irq/write/read/wake/drop fields
// csr       csr_we, csr_wdata              echo_enable
//
// one item per cycle sustained while the response side keeps popping; an accepted
// item passes through the front command queue and then one back-end step into the
// result queue, where it can be popped
// the back end updates the three byte fifos as it takes each item
// synchronous reset empties all queues and clears echo_enable and tx irq
// a stalled response side fills the two-entry result queue, then the
// two-entry command queue, then raises full

module uart_tty_queue_engine (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   output logic                        full,
   input  wire uttq_pkg::req_item_type req_item,
   output logic                        empty,
   input  wire logic                   pop,
   output uttq_pkg::rsp_item_type      rsp_item,
   input  wire logic                   csr_we,
   input  wire logic                   csr_wdata
);

   logic              cmd_valid;
   logic              cmd_pop;
   uttq_pkg::cmd_type cmd;

   uttq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   uttq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

/* rtl/core/uttq_byte_fifo.sv */
`default_nettype none

module uttq_byte_fifo (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire logic [7:0]               push_data,
   input  wire logic                     pop,
   output uttq_pkg::fifo_status_type     status,
   output logic [7:0]                    head
);

   logic [7:0]                  mem_ff [uttq_pkg::FIFO_DEPTH];
   logic [uttq_pkg::PTR_W-1:0]  rd_ff, rd_in;
   logic [uttq_pkg::PTR_W-1:0]  wr_ff, wr_in;
   logic [uttq_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                        do_push, do_pop;

   assign status.full  = (cnt_ff == uttq_pkg::CNT_W'(uttq_pkg::FIFO_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign head         = mem_ff[rd_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      rd_in  = do_pop  ? uttq_pkg::ptr_next(rd_ff) : rd_ff;
      wr_in  = do_push ? uttq_pkg::ptr_next(wr_ff) : wr_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/uttq_front.sv */
`default_nettype none

module uttq_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   output logic                        full,
   input  wire uttq_pkg::req_item_type req_item,
   output logic                        cmd_valid,
   output uttq_pkg::cmd_type           cmd,
   input  wire logic                   cmd_pop
);

   uttq_pkg::cmd_type                q_ff [uttq_pkg::CMDQ_DEPTH];
   logic [uttq_pkg::CMDQ_PTR_W-1:0]  rd_ff, rd_in;
   logic [uttq_pkg::CMDQ_PTR_W-1:0]  wr_ff, wr_in;
   logic [uttq_pkg::CMDQ_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                             do_push, do_pop;
   uttq_pkg::cmd_type                classified;

   // every 2-bit code is a valid request kind
   assign classified.op   = uttq_pkg::op_type'(req_item.req_type);
   assign classified.data = req_item.data;

   assign full      = (cnt_ff == uttq_pkg::CMDQ_CNT_W'(uttq_pkg::CMDQ_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ff];

   assign do_push = push && !full;
   assign do_pop  = cmd_pop && cmd_valid;

   always_comb begin
      rd_in = rd_ff;
      wr_in = wr_ff;
      if (do_pop) begin
         rd_in = (rd_ff == uttq_pkg::CMDQ_PTR_W'(uttq_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push) begin
         wr_in = (wr_ff == uttq_pkg::CMDQ_PTR_W'(uttq_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= classified;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/uttq_back.sv */
`default_nettype none

module uttq_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic                    csr_wdata,
   input  wire logic                    cmd_valid,
   input  wire uttq_pkg::cmd_type       cmd,
   output logic                         cmd_pop,
   output logic                         empty,
   input  wire logic                    pop,
   output uttq_pkg::rsp_item_type       rsp_item
);

   logic echo_enable_ff;
   logic tx_irq_ff, tx_irq_in;

   uttq_pkg::fifo_status_type rx_stat, echo_stat, tx_stat;
   logic [7:0]                rx_head, echo_head, tx_head;
   logic                      rx_push, rx_pop, echo_push, echo_pop, tx_push, tx_pop;

   uttq_pkg::rsp_item_type           res;
   uttq_pkg::rsp_item_type           rq_ff [uttq_pkg::RSPQ_DEPTH];
   logic [uttq_pkg::RSPQ_PTR_W-1:0]  rq_rd_ff, rq_rd_in;
   logic [uttq_pkg::RSPQ_PTR_W-1:0]  rq_wr_ff, rq_wr_in;
   logic [uttq_pkg::RSPQ_CNT_W-1:0]  rq_cnt_ff, rq_cnt_in;
   logic                             rq_full, rq_pop, go;

   uttq_byte_fifo u_rx_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rx_push),
      .push_data (cmd.data),
      .pop       (rx_pop),
      .status    (rx_stat),
      .head      (rx_head)
   );

   uttq_byte_fifo u_echo_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (echo_push),
      .push_data (cmd.data),
      .pop       (echo_pop),
      .status    (echo_stat),
      .head      (echo_head)
   );

   uttq_byte_fifo u_tx_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (tx_push),
      .push_data (cmd.data),
      .pop       (tx_pop),
      .status    (tx_stat),
      .head      (tx_head)
   );

   assign rq_full = (rq_cnt_ff == uttq_pkg::RSPQ_CNT_W'(uttq_pkg::RSPQ_DEPTH));
   assign empty   = (rq_cnt_ff == '0);
   assign rq_pop  = pop && !empty;
   assign go      = cmd_valid && (!rq_full || rq_pop);
   assign cmd_pop = go;
   assign rsp_item = rq_ff[rq_rd_ff];

   always_comb begin
      rx_push   = 1'b0;
      rx_pop    = 1'b0;
      echo_push = 1'b0;
      echo_pop  = 1'b0;
      tx_push   = 1'b0;
      tx_pop    = 1'b0;
      tx_irq_in = tx_irq_ff;
      res       = '0;
      if (go) begin
         unique case (cmd.op)
            uttq_pkg::OP_RX_BYTE: begin
               rx_push        = 1'b1;
               res.rx_dropped = rx_stat.full;
               if (echo_enable_ff) begin
                  echo_push = 1'b1;
                  // first byte into an empty echo queue turns tx interrupts on
                  if (echo_stat.empty) begin
                     tx_irq_in = 1'b1;
                  end
               end
            end
            uttq_pkg::OP_TX_EMPTY: begin
               if (!echo_stat.empty) begin
                  echo_pop     = 1'b1;
                  res.tx_valid = 1'b1;
                  res.tx_char  = echo_head;
               end else if (!tx_stat.empty) begin
                  tx_pop          = 1'b1;
                  res.tx_valid    = 1'b1;
                  res.tx_char     = tx_head;
                  res.wake_writer = 1'b1;
               end else begin
                  tx_irq_in = 1'b0;
               end
            end
            uttq_pkg::OP_HOST_WRITE: begin
               tx_push            = 1'b1;
               res.write_accepted = !tx_stat.full;
               tx_irq_in          = 1'b1;
            end
            uttq_pkg::OP_HOST_READ: begin
               if (!rx_stat.empty) begin
                  rx_pop         = 1'b1;
                  res.read_valid = 1'b1;
                  res.read_char  = rx_head;
               end
            end
            default: begin
               tx_irq_in = tx_irq_ff;
            end
         endcase
      end
      res.tx_irq_enable = tx_irq_in;
   end

   always_comb begin
      rq_rd_in = rq_rd_ff;
      rq_wr_in = rq_wr_ff;
      if (rq_pop) begin
         rq_rd_in = (rq_rd_ff == uttq_pkg::RSPQ_PTR_W'(uttq_pkg::RSPQ_DEPTH - 1)) ?
                    '0 : rq_rd_ff + 1'b1;
      end
      if (go) begin
         rq_wr_in = (rq_wr_ff == uttq_pkg::RSPQ_PTR_W'(uttq_pkg::RSPQ_DEPTH - 1)) ?
                    '0 : rq_wr_ff + 1'b1;
      end
      rq_cnt_in = rq_cnt_ff;
      if (go && !rq_pop) begin
         rq_cnt_in = rq_cnt_ff + 1'b1;
      end else if (rq_pop && !go) begin
         rq_cnt_in = rq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_enable_ff <= 1'b0;
         tx_irq_ff      <= 1'b0;
         rq_rd_ff       <= '0;
         rq_wr_ff       <= '0;
         rq_cnt_ff      <= '0;
      end else begin
         if (csr_we) begin
            echo_enable_ff <= csr_wdata;
         end
         tx_irq_ff <= tx_irq_in;
         rq_rd_ff  <= rq_rd_in;
         rq_wr_ff  <= rq_wr_in;
         rq_cnt_ff <= rq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rq_ff[rq_wr_ff] <= res;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/uttq_checker.sv */
`default_nettype none

module uttq_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   empty,
   input wire logic                   pop,
   input wire uttq_pkg::rsp_item_type rsp_item
);

   // queues come up empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> empty)
      else $error("response side not empty after reset");

   // a pending item is held until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_item))
      else $error("pending item changed while stalled");

   // a send comes from exactly one request kind
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_item.tx_valid |->
         !rsp_item.read_valid && !rsp_item.write_accepted && !rsp_item.rx_dropped)
      else $error("send mixed with another request kind");

   // bytes only go out while tx interrupts are on
   a_tx_irq: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_item.tx_valid |-> rsp_item.tx_irq_enable)
      else $error("byte sent with tx interrupts off");

   // wake only accompanies a real send, idle chars read as zero
   a_wake: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (!rsp_item.wake_writer || rsp_item.tx_valid) &&
                 (rsp_item.tx_valid || rsp_item.tx_char == 8'd0) &&
                 (rsp_item.read_valid || rsp_item.read_char == 8'd0))
      else $error("wake or char field inconsistent with its valid");

endmodule

bind uart_tty_queue_engine uttq_checker u_uttq_checker (
   .clock    (clock),
   .reset    (reset),
   .empty    (empty),
   .pop      (pop),
   .rsp_item (rsp_item)
);

`default_nettype wire

/* verif/tb_uart_tty_queue_engine.sv */
`default_nettype none

module tb_uart_tty_queue_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RXQ = 0;
   localparam int ECHOQ = 1;
   localparam int TXQ = 2;

   localparam int MODE_FILL_RX = 0;
   localparam int MODE_DRAIN_RX = 1;
   localparam int MODE_FILL_TX = 2;
   localparam int MODE_DRAIN_TX = 3;
   localparam int MODE_MIXED = 4;

   localparam int PHASE_ITEMS = 330;
   localparam int CHUNK_ITEMS = 30;
   localparam int DRAIN_CYCLES = 8;
   localparam int WATCHDOG_LIMIT = 1000;

   // mirror of the three byte fifos plus irq enable, and the items it predicts
   class tty_line_model;
      logic [7:0]             mem [3][uttq_pkg::FIFO_DEPTH];
      int unsigned            rd [3];
      int unsigned            cnt [3];
      bit                     echo_on;
      bit                     irq_on;
      uttq_pkg::rsp_item_type expected_rsp_q[$];
      int unsigned            mismatches;

      function new();
         foreach (mem[k, i]) mem[k][i] = '0;
         foreach (rd[k]) begin
            rd[k] = 0;
            cnt[k] = 0;
         end
         echo_on = 1'b0;
         irq_on = 1'b0;
         mismatches = 0;
      endfunction

      function bit put(int k, logic [7:0] b);
         if (cnt[k] >= uttq_pkg::FIFO_DEPTH) return 1'b0;
         mem[k][(rd[k] + cnt[k]) % uttq_pkg::FIFO_DEPTH] = b;
         cnt[k]++;
         return 1'b1;
      endfunction

      function logic [7:0] take(int k);
         logic [7:0] b;
         b = mem[k][rd[k]];
         rd[k] = (rd[k] + 1) % uttq_pkg::FIFO_DEPTH;
         cnt[k]--;
         return b;
      endfunction

      function void note_input(uttq_pkg::req_item_type it);
         uttq_pkg::rsp_item_type r;
         r = '0;
         case (uttq_pkg::op_type'(it.req_type))
            uttq_pkg::OP_RX_BYTE: begin
               r.rx_dropped = !put(RXQ, it.data);
               // echo still sees the byte when the receive side dropped it
               if (echo_on) begin
                  void'(put(ECHOQ, it.data));
                  if (cnt[ECHOQ] == 1) irq_on = 1'b1;
               end
            end
            uttq_pkg::OP_TX_EMPTY: begin
               if (cnt[ECHOQ] != 0) begin
                  r.tx_char = take(ECHOQ);
                  r.tx_valid = 1'b1;
               end else if (cnt[TXQ] != 0) begin
                  r.tx_char = take(TXQ);
                  r.tx_valid = 1'b1;
                  r.wake_writer = 1'b1;
               end else begin
                  irq_on = 1'b0;
               end
            end
            uttq_pkg::OP_HOST_WRITE: begin
               r.write_accepted = put(TXQ, it.data);
               irq_on = 1'b1;
            end
            default: begin
               if (cnt[RXQ] != 0) begin
                  r.read_char = take(RXQ);
                  r.read_valid = 1'b1;
               end
            end
         endcase
         r.tx_irq_enable = irq_on;
         expected_rsp_q.push_back(r);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            mismatches++;
            $error("%s: expected %0h, actual %0h", name, want, got);
         end
      endfunction

      function void check_result(uttq_pkg::rsp_item_type got);
         uttq_pkg::rsp_item_type want;
         if (expected_rsp_q.size() == 0) begin
            mismatches++;
            $error("result item %h with nothing expected", got);
            return;
         end
         want = expected_rsp_q.pop_front();
         compare_field("tx_valid", want.tx_valid, got.tx_valid);
         compare_field("tx_char", want.tx_char, got.tx_char);
         compare_field("tx_irq_enable", want.tx_irq_enable, got.tx_irq_enable);
         compare_field("write_accepted", want.write_accepted, got.write_accepted);
         compare_field("read_valid", want.read_valid, got.read_valid);
         compare_field("read_char", want.read_char, got.read_char);
         compare_field("wake_writer", want.wake_writer, got.wake_writer);
         compare_field("rx_dropped", want.rx_dropped, got.rx_dropped);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   push = 1'b0;
   logic                   full;
   uttq_pkg::req_item_type req_item = '0;
   logic                   empty;
   logic                   pop = 1'b0;
   uttq_pkg::rsp_item_type rsp_item;
   logic                   csr_we = 1'b0;
   logic                   csr_wdata = 1'b0;

   int           send_idle_pct = 13;
   int           recv_idle_pct = 60;
   int           stall_cycles = 0;

   tty_line_model line_model = new();

   uart_tty_queue_engine u_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) line_model.note_input(req_item);
         if (pop && !empty) line_model.check_result(rsp_item);
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_uart_tty_queue_engine failed");
            $finish;
         end
      end
   end

   task automatic send_item(uttq_pkg::op_type op, logic [7:0] d);
      uttq_pkg::req_item_type it;
      it.req_type = op;
      it.data = d;
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      @(posedge clock);
      while (line_model.expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_echo(logic v);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      line_model.echo_on = v;
   endtask

   function automatic uttq_pkg::op_type pick_op(int mode);
      int r;
      r = $urandom_range(99);
      case (mode)
         MODE_FILL_RX:
            return r < 70 ? uttq_pkg::OP_RX_BYTE : r < 80 ? uttq_pkg::OP_TX_EMPTY :
                   r < 90 ? uttq_pkg::OP_HOST_WRITE : uttq_pkg::OP_HOST_READ;
         MODE_DRAIN_RX:
            return r < 15 ? uttq_pkg::OP_RX_BYTE : r < 30 ? uttq_pkg::OP_TX_EMPTY :
                   r < 40 ? uttq_pkg::OP_HOST_WRITE : uttq_pkg::OP_HOST_READ;
         MODE_FILL_TX:
            return r < 10 ? uttq_pkg::OP_RX_BYTE : r < 25 ? uttq_pkg::OP_TX_EMPTY :
                   r < 85 ? uttq_pkg::OP_HOST_WRITE : uttq_pkg::OP_HOST_READ;
         MODE_DRAIN_TX:
            return r < 15 ? uttq_pkg::OP_RX_BYTE : r < 75 ? uttq_pkg::OP_TX_EMPTY :
                   r < 90 ? uttq_pkg::OP_HOST_WRITE : uttq_pkg::OP_HOST_READ;
         default:
            return uttq_pkg::op_type'($urandom_range(3));
      endcase
   endfunction

   initial begin
      int mode;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // echo off after reset: read and tx-empty on empty fifos, then overfill rx
      send_item(uttq_pkg::OP_HOST_READ, 8'hFF);
      send_item(uttq_pkg::OP_TX_EMPTY, 8'h00);
      send_item(uttq_pkg::OP_RX_BYTE, 8'h00);
      send_item(uttq_pkg::OP_RX_BYTE, 8'hFF);
      for (int i = 0; i < 7; i++) send_item(uttq_pkg::OP_RX_BYTE, 8'($urandom_range(255)));
      wait_drained();
      set_echo(1'b1);
      // rx full but echo still takes the byte and raises the irq enable
      send_item(uttq_pkg::OP_RX_BYTE, 8'h5A);
      send_item(uttq_pkg::OP_TX_EMPTY, 8'h00);
      send_item(uttq_pkg::OP_HOST_WRITE, 8'h00);
      send_item(uttq_pkg::OP_HOST_WRITE, 8'hFF);
      for (int i = 0; i < 7; i++) send_item(uttq_pkg::OP_HOST_WRITE, 8'($urandom_range(255)));
      send_item(uttq_pkg::OP_TX_EMPTY, 8'hA5);
      send_item(uttq_pkg::OP_HOST_READ, 8'h00);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         case (p / 2)
            0: begin
               send_idle_pct = 13;
               recv_idle_pct = 60;
            end
            1: begin
               send_idle_pct = 60;
               recv_idle_pct = 13;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         set_echo(p % 2 == 0);
         mode = MODE_MIXED;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % CHUNK_ITEMS == 0) mode = $urandom_range(MODE_MIXED);
            if ($urandom_range(149) == 0) wait_drained();
            send_item(pick_op(mode), 8'($urandom_range(255)));
         end
         wait_drained();
      end

      if (line_model.mismatches == 0 && line_model.expected_rsp_q.size() == 0)
         $display("tb_uart_tty_queue_engine passed");
      else
         $display("tb_uart_tty_queue_engine failed");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/uttq_pkg.sv
rtl/core/uttq_byte_fifo.sv
rtl/core/uttq_front.sv
rtl/core/uttq_back.sv
rtl/core/uart_tty_queue_engine.sv
rtl/core/uttq_checker.sv
verif/tb_uart_tty_queue_engine.sv
